@@ sv/fwad_pkg.sv @@
// Package with types, constants and helpers of the flow window anomaly detector.
`default_nettype none
package fwad_pkg;

	localparam int NUM_FLOWS_DEF = 64;
	localparam int WINDOW_DEF    = 100;

	localparam logic [3:0] SCORE_BW    = 4'd3;
	localparam logic [3:0] SCORE_RATE  = 4'd3;
	localparam logic [3:0] SCORE_FLOOD = 4'd4;
	localparam logic [3:0] SCORE_LIMIT = 4'd5;

	localparam logic [15:0] WINDOW_TICKS_RST = 16'd1000;
	localparam logic [11:0] BW_LIMIT_RST     = 12'd10;
	localparam logic [9:0]  RATE_LIMIT_RST   = 10'd1000;
	localparam logic [9:0]  FLOOD_MIN_RST    = 10'd500;
	localparam logic [15:0] FLOOD_AVG_RST    = 16'd100;

	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_TICKS = 3'd0,
		CFG_BW_LIMIT     = 3'd1,
		CFG_RATE_LIMIT   = 3'd2,
		CFG_FLOOD_MIN    = 3'd3,
		CFG_FLOOD_AVG    = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_RECORD = 2'd2,
		OP_DETECT = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [5:0]  flow_id;
		logic [15:0] rx_bytes;
		logic [15:0] tx_bytes;
		logic [31:0] timestamp;
	} req_t;

	typedef struct packed {
		logic       flow_found;
		logic [2:0] anomaly_flags;
		logic [3:0] score_tenths;
		logic       anomaly;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // capture the request and read the flow table
		logic apply;      // update flow table / write ring for non-detect ops
		logic scan_start; // clear accumulators and the read index
		logic scan_rd;    // issue one ring read
		logic acc;        // accumulate the entry read in the previous cycle
		logic eval;       // compute flags
		logic done;       // present the result
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic is_detect;  // detect on a valid flow with entries
		logic last_rd;    // current read is the last ring entry
	} sts_t;

endpackage
`default_nettype wire

@@ sv/fwad_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none
module fwad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ sv/fwad_ctrl.sv @@
// Controller state machine of the flow window anomaly detector.
`default_nettype none
module fwad_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire fwad_pkg::sts_t  sts,
	output logic                 busy,
	output fwad_pkg::cmd_t       cmd
);
	import fwad_pkg::*;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.is_detect) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end else begin
					cmd.apply = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				cmd.acc = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				cmd.done = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// A read issued in the previous scan cycle lands now.
		if (state_q == ST_SCAN && state_d == ST_SCAN) begin
			cmd.acc = 1'b0;
		end
	end
endmodule
`default_nettype wire

@@ sv/fwad_dp.sv @@
// Datapath of the flow window anomaly detector: flow table, ring memories, accumulators.
`default_nettype none
module fwad_dp #(
	parameter int NUM_FLOWS = fwad_pkg::NUM_FLOWS_DEF,
	parameter int WINDOW    = fwad_pkg::WINDOW_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fwad_pkg::req_t  req,
	input  wire fwad_pkg::cmd_t  cmd,
	input  wire logic [15:0]     window_ticks,
	input  wire logic [11:0]     bandwidth_limit_mib,
	input  wire logic [9:0]      packet_rate_limit,
	input  wire logic [9:0]      flood_min_packets,
	input  wire logic [15:0]     flood_avg_bytes,
	output fwad_pkg::sts_t       sts,
	output logic                 result_strobe,
	output fwad_pkg::rsp_t       result
);
	import fwad_pkg::*;

	localparam int FW    = (NUM_FLOWS > 1) ? $clog2(NUM_FLOWS) : 1;
	localparam int HW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW    = $clog2(WINDOW + 1);
	localparam int DEPTH = NUM_FLOWS * WINDOW;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = 17 + CW;

	req_t            req_q;
	logic            fid_ok_q;
	logic [FW-1:0]   fid_q;
	logic            found_q;
	logic [HW-1:0]   head_q;
	logic [CW-1:0]   count_q;
	logic [NUM_FLOWS-1:0] valid_q;
	logic [HW-1:0]   head_mem_q  [NUM_FLOWS];
	logic [CW-1:0]   count_mem_q [NUM_FLOWS];
	logic [AW-1:0]   base_q;
	logic [CW-1:0]   rd_idx_q;
	logic            rd_vld_q;
	logic [SW-1:0]   sum_q;
	logic [CW-1:0]   cnt_q;
	logic [2:0]      flags_q;
	logic [3:0]      score_q;
	logic [16:0]     size_rd;
	logic [31:0]     time_rd;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [AW-1:0]   rd_addr;
	logic [31:0]     age;
	logic            fid_ok;
	logic [FW-1:0]   fid;
	logic [HW-1:0]   head_nx;
	logic [31:0]     mib_lim;
	logic [SW+16-1:0] flood_lim;
	logic [2:0]      flags_d;
	logic [3:0]      score_d;

	assign fid_ok = ({26'd0, req.flow_id} < 32'(NUM_FLOWS));
	assign fid    = FW'(req.flow_id);

	// Capture the request and the addressed flow's state.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			fid_ok_q <= fid_ok;
			fid_q    <= fid;
			found_q  <= fid_ok && valid_q[fid];
			head_q   <= head_mem_q[fid];
			count_q  <= count_mem_q[fid];
			base_q   <= AW'(32'(fid) * 32'(WINDOW));
		end
	end

	assign sts.is_detect = fid_ok_q && found_q && (op_t'(req_q.opcode) == OP_DETECT)
		&& (count_q != '0);
	assign sts.last_rd   = (rd_idx_q == count_q - CW'(1));

	assign head_nx = (32'(head_q) + 32'd1 >= 32'(WINDOW)) ? '0 : HW'(32'(head_q) + 32'd1);

	// Flow table state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < NUM_FLOWS; i++) begin
				head_mem_q[i]  <= '0;
				count_mem_q[i] <= '0;
			end
		end else if (cmd.apply && fid_ok_q) begin
			unique case (op_t'(req_q.opcode))
				OP_ADD: begin
					if (!found_q) begin
						valid_q[fid_q]     <= 1'b1;
						head_mem_q[fid_q]  <= '0;
						count_mem_q[fid_q] <= '0;
					end
				end
				OP_REMOVE: valid_q[fid_q] <= 1'b0;
				OP_RECORD: begin
					if (found_q) begin
						head_mem_q[fid_q] <= head_nx;
						if (32'(count_q) < 32'(WINDOW)) begin
							count_mem_q[fid_q] <= count_q + CW'(1);
						end
					end
				end
				OP_DETECT: ;
				default: ;
			endcase
		end
	end

	assign wr_en   = cmd.apply && fid_ok_q && found_q && (op_t'(req_q.opcode) == OP_RECORD);
	assign wr_addr = base_q + AW'(head_q);
	assign rd_addr = base_q + AW'(rd_idx_q);

	fwad_ram #(.WIDTH(17), .DEPTH(DEPTH)) u_size (
		.clk(clk), .we(wr_en), .waddr(wr_addr),
		.wdata({1'b0, req_q.rx_bytes} + {1'b0, req_q.tx_bytes}),
		.raddr(rd_addr), .rdata(size_rd));

	fwad_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(req_q.timestamp),
		.raddr(rd_addr), .rdata(time_rd));

	assign age = req_q.timestamp - time_rd;

	// Scan the ring one entry per cycle and accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rd_vld_q <= 1'b0;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			rd_vld_q <= cmd.scan_rd;
			if (cmd.scan_start) begin
				rd_idx_q <= '0;
				sum_q    <= '0;
				cnt_q    <= '0;
			end else begin
				if (cmd.scan_rd) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
				if (rd_vld_q && (age < {16'd0, window_ticks})) begin
					sum_q <= sum_q + SW'(size_rd);
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	assign mib_lim   = {bandwidth_limit_mib, 20'd0};
	assign flood_lim = (SW+16)'(flood_avg_bytes) * (SW+16)'(cnt_q);

	// Flag evaluation.
	always_comb begin
		flags_d = '0;
		score_d = '0;
		if (33'(sum_q) > {1'b0, mib_lim}) begin
			flags_d[0] = 1'b1;
			score_d    = score_d + SCORE_BW;
		end
		if (32'(cnt_q) > 32'(packet_rate_limit)) begin
			flags_d[1] = 1'b1;
			score_d    = score_d + SCORE_RATE;
		end
		if ((32'(cnt_q) > 32'(flood_min_packets)) && ((SW+16)'(sum_q) < flood_lim)) begin
			flags_d[2] = 1'b1;
			score_d    = score_d + SCORE_FLOOD;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flags_q <= '0;
			score_q <= '0;
		end else if (cmd.eval) begin
			flags_q <= flags_d;
			score_q <= score_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			result.flow_found    <= fid_ok_q && found_q;
			result.anomaly_flags <= flags_q;
			result.score_tenths  <= score_q;
			result.anomaly       <= (score_q > SCORE_LIMIT);
		end
	end
endmodule
`default_nettype wire

@@ sv/flow_window_anomaly_detector_core.sv @@
// Add, remove, record and detect on an invalid or empty flow pass through the lookup and done
// states; detect on a flow holding ring entries passes through lookup, scan (one ring memory read
// per cycle), drain, eval and done. A new request is taken at the result's edge.
// One request at a time: busy is high from acceptance until the result strobe.
// The result is shown for one cycle on result with result_valid; it cannot be stalled.
// Asynchronous reset clears the flow table and the configuration registers to their defaults;
// ring memories are not cleared and need no clearing pass.
`default_nettype none
module flow_window_anomaly_detector_core #(
	parameter int NUM_FLOWS = fwad_pkg::NUM_FLOWS_DEF,
	parameter int WINDOW    = fwad_pkg::WINDOW_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire fwad_pkg::req_t                      req,
	output logic                                     result_valid,
	output fwad_pkg::rsp_t                           result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [fwad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [15:0]                         cfg_data
);
	import fwad_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic [15:0] window_ticks_q;
	logic [11:0] bw_limit_q;
	logic [9:0]  rate_limit_q;
	logic [9:0]  flood_min_q;
	logic [15:0] flood_avg_q;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_ticks_q <= WINDOW_TICKS_RST;
			bw_limit_q     <= BW_LIMIT_RST;
			rate_limit_q   <= RATE_LIMIT_RST;
			flood_min_q    <= FLOOD_MIN_RST;
			flood_avg_q    <= FLOOD_AVG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW_TICKS: window_ticks_q <= cfg_data;
				CFG_BW_LIMIT:     bw_limit_q     <= cfg_data[11:0];
				CFG_RATE_LIMIT:   rate_limit_q   <= cfg_data[9:0];
				CFG_FLOOD_MIN:    flood_min_q    <= cfg_data[9:0];
				CFG_FLOOD_AVG:    flood_avg_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	fwad_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd));

	fwad_dp #(.NUM_FLOWS(NUM_FLOWS), .WINDOW(WINDOW)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd),
		.window_ticks(window_ticks_q), .bandwidth_limit_mib(bw_limit_q),
		.packet_rate_limit(rate_limit_q), .flood_min_packets(flood_min_q),
		.flood_avg_bytes(flood_avg_q), .sts(sts),
		.result_strobe(result_valid), .result(result));

	// A result never appears while no request is in flight.
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without a request");

	// The anomaly bit follows the score.
	a_anomaly: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.anomaly == (result.score_tenths > SCORE_LIMIT)))
		else $error("anomaly bit mismatch");

	// An accepted request raises busy in the next cycle.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accept without busy");
endmodule
`default_nettype wire

@@ tb/flow_window_anomaly_detector_core_checker.sv @@
// Checker that predicts and compares the detector's results.
`timescale 1ns / 1ps
module flow_window_anomaly_detector_core_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  fwad_pkg::req_t  req,
	input  logic            result_valid,
	input  fwad_pkg::rsp_t  result,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data,
	output int              fail_count,
	output int              pending_count
);
	import fwad_pkg::*;

	localparam int FLOWS = NUM_FLOWS_DEF;
	localparam int WIN   = WINDOW_DEF;

	// Register copies.
	logic [15:0] win_ticks;
	logic [11:0] bw_mib;
	logic [9:0]  rate_lim;
	logic [9:0]  flood_min;
	logic [15:0] flood_avg;

	// Flow table copy.
	logic        valid_tbl [FLOWS];
	int          head_tbl  [FLOWS];
	int          count_tbl [FLOWS];
	logic [16:0] size_mem  [FLOWS*WIN];
	logic [31:0] time_mem  [FLOWS*WIN];

	rsp_t expected_rsp_q[$];

	assign pending_count = expected_rsp_q.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	// Apply one request to the table copy and return its expected result.
	function automatic rsp_t predict_detector(input req_t r);
		rsp_t o;
		int fid;
		logic [63:0] sum;
		int cnt;
		logic [31:0] age;
		o = '0;
		sum = 0;
		cnt = 0;
		fid = r.flow_id;
		if (fid < FLOWS) begin
			o.flow_found = valid_tbl[fid];
			case (op_t'(r.opcode))
				OP_ADD: if (!valid_tbl[fid]) begin
					valid_tbl[fid] = 1'b1;
					head_tbl[fid] = 0;
					count_tbl[fid] = 0;
				end
				OP_REMOVE: valid_tbl[fid] = 1'b0;
				OP_RECORD: if (valid_tbl[fid]) begin
					size_mem[fid*WIN + head_tbl[fid]] = {1'b0, r.rx_bytes} + r.tx_bytes;
					time_mem[fid*WIN + head_tbl[fid]] = r.timestamp;
					head_tbl[fid] = (head_tbl[fid] + 1 >= WIN) ? 0 : head_tbl[fid] + 1;
					if (count_tbl[fid] < WIN) count_tbl[fid]++;
				end
				default: if (valid_tbl[fid]) begin
					for (int i = 0; i < count_tbl[fid]; i++) begin
						age = r.timestamp - time_mem[fid*WIN + i];
						if (age < {16'd0, win_ticks}) begin
							sum += size_mem[fid*WIN + i];
							cnt++;
						end
					end
					if (sum > 64'(bw_mib) * 64'd1048576) begin
						o.anomaly_flags[0] = 1'b1;
						o.score_tenths += SCORE_BW;
					end
					if (cnt > rate_lim) begin
						o.anomaly_flags[1] = 1'b1;
						o.score_tenths += SCORE_RATE;
					end
					if (cnt > flood_min && sum < 64'(flood_avg) * cnt) begin
						o.anomaly_flags[2] = 1'b1;
						o.score_tenths += SCORE_FLOOD;
					end
					o.anomaly = o.score_tenths > SCORE_LIMIT;
				end
			endcase
		end
		return o;
	endfunction

	// Watch the channels at each edge.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			win_ticks <= WINDOW_TICKS_RST;
			bw_mib <= BW_LIMIT_RST;
			rate_lim <= RATE_LIMIT_RST;
			flood_min <= FLOOD_MIN_RST;
			flood_avg <= FLOOD_AVG_RST;
			for (int f = 0; f < FLOWS; f++) begin
				valid_tbl[f] = 1'b0;
				head_tbl[f] = 0;
				count_tbl[f] = 0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_TICKS: win_ticks <= cfg_data;
					CFG_BW_LIMIT:     bw_mib <= cfg_data[11:0];
					CFG_RATE_LIMIT:   rate_lim <= cfg_data[9:0];
					CFG_FLOOD_MIN:    flood_min <= cfg_data[9:0];
					CFG_FLOOD_AVG:    flood_avg <= cfg_data;
					default: ;
				endcase
			end
			if (result_valid) begin
				if (expected_rsp_q.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_rsp_q.pop_front();
					if (result.flow_found !== want.flow_found)
						report_mismatch("flow_found", result.flow_found, want.flow_found);
					if (result.anomaly_flags !== want.anomaly_flags)
						report_mismatch("anomaly_flags", result.anomaly_flags,
							want.anomaly_flags);
					if (result.score_tenths !== want.score_tenths)
						report_mismatch("score_tenths", result.score_tenths,
							want.score_tenths);
					if (result.anomaly !== want.anomaly)
						report_mismatch("anomaly", result.anomaly, want.anomaly);
				end
			end
			if (start && !busy)
				expected_rsp_q.push_back(predict_detector(req));
		end
	end

	initial fail_count = 0;
endmodule

@@ tb/flow_window_anomaly_detector_core_tb.sv @@
// Top of the testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module flow_window_anomaly_detector_core_tb;
	import fwad_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        req;
	logic        result_valid;
	rsp_t        result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending_count;
	int          cycle_count;
	int          idle_pct;

	flow_window_anomaly_detector_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	flow_window_anomaly_detector_core_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog on total cycles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 900000) begin
			$display("FAIL flow_window_anomaly_detector_core");
			$finish;
		end
	end

	// Send one request, with an optional random gap first.
	// Busy is sampled at the falling edge so the accepting rising edge is known exactly.
	task automatic send_request(input op_t op, input int fid, input logic [15:0] bi,
			input logic [15:0] bo, input logic [31:0] ts);
		while ($urandom_range(99) < idle_pct) @(posedge clk);
		start <= 1'b1;
		req <= '{opcode: op, flow_id: fid[5:0], rx_bytes: bi, tx_bytes: bo, timestamp: ts};
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until all requests have answered and the block is quiet.
	task automatic drain_block;
		while (pending_count != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input cfg_idx_t idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] w, input logic [15:0] bw,
			input logic [15:0] rl, input logic [15:0] fm, input logic [15:0] fa);
		write_register(CFG_WINDOW_TICKS, w);
		write_register(CFG_BW_LIMIT, bw);
		write_register(CFG_RATE_LIMIT, rl);
		write_register(CFG_FLOOD_MIN, fm);
		write_register(CFG_FLOOD_AVG, fa);
	endtask

	// Random traffic phase; a few flows get most records so detects see rings with many entries.
	task automatic random_phase(input int n, input logic [31:0] base);
		logic [31:0] now;
		int fid;
		int sel;
		now = base;
		for (int i = 0; i < n; i++) begin
			fid = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(3);
			sel = $urandom_range(99);
			now += $urandom_range(20);
			if (sel < 4) send_request(OP_ADD, fid, 16'($urandom), 16'($urandom),
				32'($urandom));
			else if (sel < 6) send_request(OP_REMOVE, fid, 16'($urandom), 16'($urandom), now);
			else if (sel < 80) send_request(OP_RECORD, fid,
				($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(200)),
				16'($urandom),
				($urandom_range(9) == 0) ? 32'($urandom) : now);
			else send_request(OP_DETECT, fid, 16'($urandom), 16'($urandom), now);
			if (i == n / 2) drain_block();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycle_count = 0;
		idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every operation, invalid flows, extremes, wrapped ages.
		send_request(OP_DETECT, 63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(OP_RECORD, 0, 16'd1, 16'd1, 32'd0);
		send_request(OP_ADD, 0, 16'd0, 16'd0, 32'd0);
		send_request(OP_ADD, 0, 16'd0, 16'd0, 32'd0);
		send_request(OP_DETECT, 0, 16'd0, 16'd0, 32'd5);
		send_request(OP_ADD, 63, 16'd0, 16'd0, 32'd0);
		send_request(OP_RECORD, 63, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFF0);
		send_request(OP_RECORD, 63, 16'd0, 16'd0, 32'd10);
		send_request(OP_RECORD, 63, 16'd7, 16'd9, 32'd100);
		send_request(OP_DETECT, 63, 16'd0, 16'd0, 32'd20);
		send_request(OP_DETECT, 63, 16'd0, 16'd0, 32'd0);
		send_request(OP_REMOVE, 63, 16'd0, 16'd0, 32'd0);
		send_request(OP_DETECT, 63, 16'd0, 16'd0, 32'd20);
		send_request(OP_REMOVE, 5, 16'd0, 16'd0, 32'd0);
		drain_block();

		// Extreme settings: zero window, zero limits.
		write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_request(OP_ADD, 1, 16'd0, 16'd0, 32'd0);
		send_request(OP_RECORD, 1, 16'd3, 16'd4, 32'd50);
		send_request(OP_DETECT, 1, 16'd0, 16'd0, 32'd50);
		drain_block();
		write_all(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF);
		send_request(OP_DETECT, 1, 16'd0, 16'd0, 32'd60);
		drain_block();

		// Low thresholds so every flag can fire in random traffic.
		write_all(16'd600, 16'd1, 16'd40, 16'd30, 16'd120);
		idle_pct = 28;
		random_phase(170, 32'd1000);
		drain_block();

		write_all(16'hFFFF, 16'd4095, 16'd1023, 16'd1023, 16'hFFFF);
		idle_pct = 83;
		random_phase(120, 32'hFFFF_FF00);
		drain_block();

		write_all(16'd2000, 16'd0, 16'd20, 16'd10, 16'd60000);
		idle_pct = 0;
		random_phase(200, 32'h8000_0000);
		drain_block();

		if (fail_count == 0) begin
			$display("PASS flow_window_anomaly_detector_core");
		end else begin
			$display("FAIL flow_window_anomaly_detector_core");
		end
		$finish;
	end
endmodule
